/* hdl/xcfr_pkg.sv */
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants for the checked frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package xcfr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [7:0] SOF_RESET = 8'd126;

    typedef enum logic [1:0] {
        RES_MORE = 2'd0,
        RES_DONE = 2'd1,
        RES_BAD  = 2'd2
    } res_t;

    typedef struct packed {
        logic take;
        logic rep_load;
        logic rep_read;
        logic rep_exec;
        logic emit_init;
        logic emit_read;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        res_t res;
        logic rep_last;
        logic em_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

/* hdl/xor_checked_frame_receiver_resync_unit.sv */
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_resync_unit
// Start/type/length/payload/XOR-checksum frame receiver with resync on error.
// ----------------------------------------------------------------------------
// An ordinary received byte is taken directly in the idle state. A byte
// that completes a good frame starts emission: each result takes a read of
// the payload memory, then a load of the output register once it is free,
// and no byte is taken until the last result of the frame has been loaded.
// A bad checksum byte starts a rescan of the failed frame, a memory read
// then an execution for each of up to length + 3 rescanned bytes, followed
// by emission if the replayed bytes complete a frame. The output register
// lets the block take the next byte while a result still waits to be taken.
`default_nettype none

module xor_checked_frame_receiver_resync_unit
    import xcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] sof_byte,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      frame_type,
    output logic [6:0]      frame_length,
    output logic [5:0]      byte_index,
    output logic [7:0]      payload_byte,
    output logic            has_byte,
    output logic            last
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    xcfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    xcfr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .sof_byte     (sof_byte),
        .rx_byte      (rx_byte),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .frame_type   (frame_type),
        .frame_length (frame_length),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .has_byte     (has_byte),
        .last         (last)
    );

    a_rep_read_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rep_read |=> cmd.rep_exec)
        else $error("Replay read was not followed by replay execution.");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_load |-> (!out_valid || out_ready))
        else $error("Result loaded over a pending output transaction.");

    a_done_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && status.res == RES_DONE) |=> !in_ready)
        else $error("Input accepted while a completed frame is being emitted.");

endmodule

`default_nettype wire

/* hdl/xcfr_ctrl.sv */
// ----------------------------------------------------------------------------
// xcfr_ctrl
// Sequencer for byte intake, checksum-failure replay and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_ctrl
    import xcfr_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [2:0] {
        IDLE,
        REP_RD,
        REP_EX,
        EMIT_RD,
        EMIT_WR
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.res == RES_DONE)
                    begin
                        cmd.emit_init = 1'b1;
                        state_next    = EMIT_RD;
                    end
                    else if (status.res == RES_BAD)
                    begin
                        cmd.rep_load = 1'b1;
                        state_next   = REP_RD;
                    end
                end
            end
            REP_RD:
            begin
                cmd.rep_read = 1'b1;
                state_next   = REP_EX;
            end
            REP_EX:
            begin
                cmd.rep_exec = 1'b1;
                if (status.res == RES_DONE)
                begin
                    cmd.emit_init = 1'b1;
                    state_next    = EMIT_RD;
                end
                else if (status.res == RES_BAD || status.rep_last)
                begin
                    state_next = IDLE;
                end
                else
                begin
                    state_next = REP_RD;
                end
            end
            EMIT_RD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = EMIT_WR;
            end
            EMIT_WR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = status.em_last ? IDLE : EMIT_RD;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/xcfr_datapath.sv */
// ----------------------------------------------------------------------------
// xcfr_datapath
// Frame parser registers, payload memory, replay source and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module xcfr_datapath
    import xcfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    output status_t         status,
    input  wire logic       cfg_valid,
    input  wire logic [7:0] sof_byte,
    input  wire logic [7:0] rx_byte,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic [7:0]      frame_type,
    output logic [6:0]      frame_length,
    output logic [5:0]      byte_index,
    output logic [7:0]      payload_byte,
    output logic            has_byte,
    output logic            last
);

    typedef enum logic [2:0] {
        PS_SOF  = 3'd0,
        PS_TYPE = 3'd1,
        PS_LEN  = 3'd2,
        PS_DATA = 3'd3,
        PS_CHK  = 3'd4
    } ps_t;

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] mem_rd_reg;

    logic [7:0] sof_reg;
    ps_t        ps_reg, ps_next;
    logic [7:0] held_type_reg, held_type_next;
    logic [6:0] held_length_reg, held_length_next;
    logic [6:0] fill_reg, fill_next;
    logic [7:0] chk_reg, chk_next;

    logic [7:0] rp_type_reg;
    logic [6:0] rp_len_reg;
    logic [7:0] rp_chk_reg;
    logic [6:0] rp_idx_reg;
    logic       rp_scan_reg;

    logic [5:0] em_idx_reg;
    logic       out_valid_reg;
    logic [7:0] out_type_reg;
    logic [6:0] out_len_reg;
    logic [5:0] out_idx_reg;
    logic [7:0] out_data_reg;
    logic       out_has_reg;
    logic       out_last_reg;

    logic [7:0]        cur_byte;
    logic [7:0]        rep_byte;
    logic [6:0]        rp_end;
    logic [6:0]        fill_inc;
    logic              adv_en;
    logic              wr_en;
    logic              match;
    res_t              res;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    assign rp_end   = rp_len_reg + 7'd2;
    assign fill_inc = fill_reg + 7'd1;

    always_comb
    begin
        if (rp_idx_reg == 7'd0)
        begin
            rep_byte = rp_type_reg;
        end
        else if (rp_idx_reg == 7'd1)
        begin
            rep_byte = {1'b0, rp_len_reg};
        end
        else if (rp_idx_reg == rp_end)
        begin
            rep_byte = rp_chk_reg;
        end
        else
        begin
            rep_byte = mem_rd_reg;
        end
    end

    assign cur_byte = cmd.rep_exec ? rep_byte : rx_byte;
    assign adv_en   = cmd.take || (cmd.rep_exec && !rp_scan_reg);
    assign match    = cmd.rep_exec && rp_scan_reg && (rep_byte == sof_reg);

    always_comb
    begin
        ps_next          = ps_reg;
        held_type_next   = held_type_reg;
        held_length_next = held_length_reg;
        fill_next        = fill_reg;
        chk_next         = chk_reg;
        wr_en            = 1'b0;
        res              = RES_MORE;
        if (match)
        begin
            ps_next = PS_TYPE;
        end
        else if (adv_en)
        begin
            unique case (ps_reg)
                PS_TYPE:
                begin
                    held_type_next = cur_byte;
                    chk_next       = cur_byte;
                    ps_next        = PS_LEN;
                end
                PS_LEN:
                begin
                    held_length_next = cur_byte[6:0];
                    fill_next        = '0;
                    chk_next         = chk_reg ^ cur_byte;
                    if (cur_byte > 8'(MAX_PAYLOAD))
                    begin
                        ps_next = PS_SOF;
                    end
                    else if (cur_byte == 8'd0)
                    begin
                        ps_next = PS_CHK;
                    end
                    else
                    begin
                        ps_next = PS_DATA;
                    end
                end
                PS_DATA:
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_inc;
                    chk_next  = chk_reg ^ cur_byte;
                    if (fill_inc >= held_length_reg)
                    begin
                        ps_next = PS_CHK;
                    end
                end
                PS_CHK:
                begin
                    ps_next = PS_SOF;
                    res     = (cur_byte == chk_reg) ? RES_DONE : RES_BAD;
                end
                default:
                begin
                    ps_next = (cur_byte == sof_reg) ? PS_TYPE : PS_SOF;
                end
            endcase
        end
    end

    assign rd_en   = cmd.rep_read || cmd.emit_read;
    assign rd_addr = cmd.rep_read ? ADDR_W'(rp_idx_reg - 7'd2) : em_idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[ADDR_W-1:0]] <= cur_byte;
        end
        if (rd_en)
        begin
            mem_rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sof_reg       <= SOF_RESET;
            ps_reg        <= PS_SOF;
            fill_reg      <= '0;
            rp_scan_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                sof_reg <= sof_byte;
            end
            ps_reg   <= ps_next;
            fill_reg <= fill_next;
            if (cmd.rep_load)
            begin
                rp_scan_reg <= 1'b1;
            end
            else if (match)
            begin
                rp_scan_reg <= 1'b0;
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_type_reg   <= held_type_next;
        held_length_reg <= held_length_next;
        chk_reg         <= chk_next;
        if (cmd.rep_load)
        begin
            rp_type_reg <= held_type_reg;
            rp_len_reg  <= held_length_reg;
            rp_chk_reg  <= cur_byte;
            rp_idx_reg  <= '0;
        end
        else if (cmd.rep_exec)
        begin
            rp_idx_reg <= rp_idx_reg + 7'd1;
        end
        if (cmd.emit_init)
        begin
            em_idx_reg <= '0;
        end
        else if (cmd.emit_load)
        begin
            em_idx_reg <= em_idx_reg + 6'd1;
        end
        if (cmd.emit_load)
        begin
            out_type_reg <= held_type_reg;
            out_len_reg  <= held_length_reg;
            out_idx_reg  <= em_idx_reg;
            out_has_reg  <= (held_length_reg != 7'd0);
            out_data_reg <= (held_length_reg != 7'd0) ? mem_rd_reg : 8'd0;
            out_last_reg <= status.em_last;
        end
    end

    assign status.res      = res;
    assign status.rep_last = (rp_idx_reg == rp_end);
    assign status.em_last  = (held_length_reg == 7'd0)
                          || ((7'(em_idx_reg) + 7'd1) == held_length_reg);
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign frame_type   = out_type_reg;
    assign frame_length = out_len_reg;
    assign byte_index   = out_idx_reg;
    assign payload_byte = out_data_reg;
    assign has_byte     = out_has_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire
